// ===== sv/mandelbrot_escape_time_pixel_macros.svh =====
// Assertion macros shared by the checker of the Mandelbrot escape-time block.
// Depends on nothing; included by the checker file only.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MET_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("escape-time block: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MET_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("escape-time block: next-cycle check failed");

`endif

// ===== sv/met_pkg.sv =====
// Shared types and constants of the Mandelbrot escape-time block.
// Depends on nothing; used by the interfaces, divider, mapper, core, top level and checker.
package met_pkg;

    localparam int REG_W   = 13;
    localparam int PIX_W   = 12;
    localparam int SHADE_W = 8;

    localparam int DEFAULT_MAX_ITER  = 255;
    localparam int DEFAULT_FRAC_BITS = 28;

    // Entries of the queue between the coordinate mapper and the iteration core.
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [REG_W-1:0] IMAGE_WIDTH_RST  = REG_W'(1920);
    localparam logic [REG_W-1:0] IMAGE_HEIGHT_RST = REG_W'(1080);

    localparam logic [SHADE_W-1:0] SHADE_MAX = SHADE_W'(255);

    // Status of the serial divider as seen by the mapper.
    typedef struct packed {
        logic done;
        logic rem_nz;
    } div_stat_t;

endpackage

// ===== sv/met_ifs.sv =====
// Handshake channels of the Mandelbrot escape-time block: pixel items in, shade items out.
// Depends on met_pkg for the payload widths.
interface met_pix_if;
    logic                       valid;
    logic                       ready;
    logic [met_pkg::PIX_W-1:0]  pixel_x;
    logic [met_pkg::PIX_W-1:0]  pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface met_shade_if;
    logic                         valid;
    logic                         ready;
    logic [met_pkg::SHADE_W-1:0]  shade;

    modport source (output valid, output shade, input ready);
    modport sink   (input valid, input shade, output ready);
endinterface

// ===== sv/met_div.sv =====
// Restoring serial divider, one quotient bit per cycle, used by the coordinate mapper.
// Depends on met_pkg for the operand width and the status struct.
module met_div #(
    parameter int SHIFT = met_pkg::DEFAULT_FRAC_BITS + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [met_pkg::REG_W-1:0]     num,
    input  logic [met_pkg::REG_W-1:0]     den,
    output logic [met_pkg::REG_W+SHIFT-1:0] quot,
    output met_pkg::div_stat_t            stat
);

    localparam int DW   = met_pkg::REG_W;
    localparam int QW   = DW + SHIFT;
    localparam int CNTW = $clog2(QW + 1);

    logic [QW-1:0]   dvd_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;

    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;

    // The quotient bits shift into the dividend register as its bits move out.
    assign trial = {rem_reg, dvd_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNTW'(QW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNTW'(1);
            done_reg <= (cnt_reg == CNTW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, {SHIFT{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[QW-2:0], fits};
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign quot        = dvd_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = (rem_reg != '0);

endmodule

// ===== sv/met_front.sv =====
// Front part: accepts pixel items and maps each to a fixed-point point c with the serial divider.
// Depends on met_pkg, met_ifs and met_div.
module met_front #(
    parameter int FRAC_BITS = met_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    met_pix_if.sink                         pixel,
    input  logic [met_pkg::REG_W-1:0]       image_width,
    input  logic [met_pkg::REG_W-1:0]       image_height,
    output logic                            push_valid,
    input  logic                            push_ready,
    output logic [2*(FRAC_BITS+4)-1:0]      push_data
);

    localparam int RW    = met_pkg::REG_W;
    localparam int CW    = FRAC_BITS + 4;
    localparam int SHIFT = FRAC_BITS + 2;
    localparam int QW    = RW + SHIFT;
    localparam int VW    = QW + 2;

    localparam logic signed [VW-1:0] TWO_C  = VW'(1) << (FRAC_BITS + 1);
    localparam logic signed [VW-1:0] LIM_HI = (VW'(1) << (FRAC_BITS + 3)) - VW'(1);
    localparam logic signed [VW-1:0] LIM_LO = -(VW'(1) << (FRAC_BITS + 3));

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_DIV_R = 2'd1;
    localparam logic [1:0] F_DIV_I = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;

    logic                      neg_reg;
    logic [met_pkg::PIX_W-1:0] y_reg;
    logic [RW-1:0]             h_reg;
    logic signed [CW-1:0]      cr_reg;
    logic signed [CW-1:0]      ci_reg;

    logic [RW-1:0]             h_eff;
    logic signed [RW:0]        diff_wh;
    logic signed [RW:0]        offset;
    logic signed [RW+1:0]      n_signed;
    logic [RW-1:0]             n_mag;
    logic                      accept;

    logic                      div_start;
    logic [RW-1:0]             div_num;
    logic [RW-1:0]             div_den;
    logic [QW-1:0]             div_quot;
    met_pkg::div_stat_t        div_stat;

    logic                      neg_sel;
    logic [VW-1:0]             q_ext;
    logic signed [VW-1:0]      c_wide;
    logic signed [CW-1:0]      c_value;

    // A zero height reads as one; the offset is the floor of half the width surplus.
    assign h_eff    = (image_height == '0) ? RW'(1) : image_height;
    assign diff_wh  = $signed({1'b0, image_width}) - $signed({1'b0, h_eff});
    assign offset   = diff_wh >>> 1;
    assign n_signed = $signed({3'b000, pixel.pixel_x}) - (RW+2)'(offset);
    assign n_mag    = n_signed[RW+1] ? RW'(-n_signed) : RW'(n_signed);

    assign pixel.ready = (state_reg == F_IDLE);
    assign accept      = pixel.valid && pixel.ready;

    assign div_start = accept || ((state_reg == F_DIV_R) && div_stat.done);
    assign div_num   = (state_reg == F_IDLE) ? n_mag : RW'(y_reg);
    assign div_den   = (state_reg == F_IDLE) ? h_eff : h_reg;

    met_div #(
        .SHIFT (SHIFT)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // For a negative numerator the floor quotient is -(q + 1) when a remainder is left,
    // which is the complement of q; without a remainder it is the complement plus one.
    assign neg_sel = (state_reg == F_DIV_R) && neg_reg;
    assign q_ext   = {2'b00, div_quot};
    assign c_wide  = (neg_sel ? ~q_ext : q_ext) + VW'(neg_sel && !div_stat.rem_nz) - TWO_C;

    always_comb
    begin
        if (c_wide < LIM_LO)
        begin
            c_value = CW'(LIM_LO);
        end
        else if (c_wide > LIM_HI)
        begin
            c_value = CW'(LIM_HI);
        end
        else
        begin
            c_value = CW'(c_wide);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_DIV_R;
                end
            end
            F_DIV_R:
            begin
                if (div_stat.done)
                begin
                    state_next = F_DIV_I;
                end
            end
            F_DIV_I:
            begin
                if (div_stat.done)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= n_signed[RW+1];
            y_reg   <= pixel.pixel_y;
            h_reg   <= h_eff;
        end
        if ((state_reg == F_DIV_R) && div_stat.done)
        begin
            cr_reg <= c_value;
        end
        if ((state_reg == F_DIV_I) && div_stat.done)
        begin
            ci_reg <= c_value;
        end
    end

    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = {cr_reg, ci_reg};

endmodule

// ===== sv/met_queue.sv =====
// Short register queue that decouples the coordinate mapper from the iteration core.
// Depends on nothing outside this file.
module met_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/met_core.sv =====
// Back part: iterates z = z*z + c for one point at a time and counts iterations until escape.
// Depends on met_pkg and met_ifs.
module met_core #(
    parameter int FRAC_BITS = met_pkg::DEFAULT_FRAC_BITS,
    parameter int MAX_ITER  = met_pkg::DEFAULT_MAX_ITER
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  logic [2*(FRAC_BITS+4)-1:0]   pop_data,
    met_shade_if.source                  result
);

    localparam int SW_OUT = met_pkg::SHADE_W;
    localparam int CW     = FRAC_BITS + 4;
    localparam int ZW     = FRAC_BITS + 5;
    localparam int PW     = 2 * ZW;
    localparam int SW     = FRAC_BITS + 11;
    localparam int KW     = $clog2(MAX_ITER + 1);
    localparam int EW     = (KW > SW_OUT) ? KW : SW_OUT;

    localparam logic signed [SW-1:0] FOUR =
        {{(SW - FRAC_BITS - 3){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_UPD  = 2'd2;
    localparam logic [1:0] B_HOLD = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [KW-1:0]           k_reg;
    logic                    out_valid_reg;
    logic [SW_OUT-1:0]       out_shade_reg;
    logic [SW_OUT-1:0]       shade_reg;

    logic signed [CW-1:0]    cr_reg;
    logic signed [CW-1:0]    ci_reg;
    logic signed [ZW-1:0]    zr_reg;
    logic signed [ZW-1:0]    zi_reg;
    logic signed [PW-1:0]    prr_reg;
    logic signed [PW-1:0]    pii_reg;
    logic signed [PW-1:0]    pri_reg;

    logic signed [CW-1:0]    cr_in;
    logic signed [CW-1:0]    ci_in;
    logic signed [SW-1:0]    rr_sq;
    logic signed [SW-1:0]    ii_sq;
    logic signed [SW-1:0]    ri_dbl;
    logic signed [SW-1:0]    zr_calc;
    logic signed [SW-1:0]    zi_calc;
    logic                    escaped;
    logic                    at_cap;
    logic [KW-1:0]           k_prev;
    logic [EW-1:0]           k_prev_ext;
    logic [SW_OUT-1:0]       shade_calc;
    logic                    take;
    logic                    load_out;

    assign cr_in = pop_data[2*CW-1:CW];
    assign ci_in = pop_data[CW-1:0];

    assign pop_ready = (state_reg == B_IDLE);
    assign take      = pop_valid && pop_ready;

    // The squares of the current z serve both the escape test of this z and the
    // next step; products are floored by an arithmetic shift of the full product.
    assign rr_sq   = SW'(prr_reg >>> FRAC_BITS);
    assign ii_sq   = SW'(pii_reg >>> FRAC_BITS);
    assign ri_dbl  = SW'(pri_reg >>> (FRAC_BITS - 1));
    assign zr_calc = rr_sq - ii_sq + SW'(cr_reg);
    assign zi_calc = ri_dbl + SW'(ci_reg);
    assign escaped = (rr_sq + ii_sq) > FOUR;
    assign at_cap  = (k_reg == KW'(MAX_ITER));

    // k counts the z values formed so far; escape at z number k means k - 1 completed.
    assign k_prev     = k_reg - KW'(1);
    assign k_prev_ext = EW'(k_prev);
    assign shade_calc = !escaped ? met_pkg::SHADE_MAX :
                        (k_prev_ext > EW'(met_pkg::SHADE_MAX)) ? met_pkg::SHADE_MAX :
                        k_prev_ext[SW_OUT-1:0];

    assign load_out = (state_reg == B_HOLD) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_UPD;
            end
            B_UPD:
            begin
                if (escaped || at_cap)
                begin
                    state_next = B_HOLD;
                end
                else
                begin
                    state_next = B_MUL;
                end
            end
            B_HOLD:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                k_reg <= KW'(1);
            end
            else if ((state_reg == B_UPD) && !escaped && !at_cap)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            // The first z after zero is c itself.
            cr_reg <= cr_in;
            ci_reg <= ci_in;
            zr_reg <= ZW'(cr_in);
            zi_reg <= ZW'(ci_in);
        end
        else if ((state_reg == B_UPD) && !escaped && !at_cap)
        begin
            zr_reg <= ZW'(zr_calc);
            zi_reg <= ZW'(zi_calc);
        end
        if (state_reg == B_MUL)
        begin
            prr_reg <= zr_reg * zr_reg;
            pii_reg <= zi_reg * zi_reg;
            pri_reg <= zr_reg * zi_reg;
        end
        if (state_reg == B_UPD)
        begin
            shade_reg <= shade_calc;
        end
        if (load_out)
        begin
            out_shade_reg <= shade_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.shade = out_shade_reg;

endmodule

// ===== sv/mandelbrot_escape_time_pixel.sv =====
// Top level of the Mandelbrot escape-time shade block: configuration registers and the
// mapper, queue and iteration core. Depends on met_pkg, met_ifs, met_front, met_queue, met_core.
//
// Each pixel item (pixel_x, pixel_y) becomes one shade item: the number of iterations of
// z = z*z + c, started from zero, that completed before |z|^2 first exceeded four, or 255
// when the point stays bounded for MAX_ITER iterations. The point c is formed in signed
// fixed point with FRAC_BITS fraction bits: the real part is (x - off) * 4 / height - 2
// with off the floor of (width - height) / 2, the imaginary part y * 4 / height - 2, each
// floored and then clamped to [-8, 8). A height of zero is taken as one. The block has two
// halves joined by a two-entry queue. The mapper runs a bit-serial divider twice per item,
// once for each part of c, then hands the point on and only then takes the next pixel. The
// iteration core owns three signed multipliers of FRAC_BITS + 5 bits; one iteration is a
// multiply state followed by an update-and-test state, and a point holds the core for
// at most MAX_ITER iterations. Sustained throughput is set by whichever half is slower
// for the current mix of points. A finished shade waits in an output register, so the core
// can finish the next point while the consumer stalls, and the mapper keeps working until
// the queue is full. Configuration writes take effect at once and must only be made while
// no item is in flight.
module mandelbrot_escape_time_pixel #(
    parameter int MAX_ITER  = met_pkg::DEFAULT_MAX_ITER,
    parameter int FRAC_BITS = met_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [met_pkg::REG_W-1:0]         cfg_data,
    met_pix_if.sink                           pixel,
    met_shade_if.source                       result
);

    localparam int PAYLOAD_W = 2 * (FRAC_BITS + 4);

    logic [met_pkg::REG_W-1:0] image_width_reg;
    logic [met_pkg::REG_W-1:0] image_height_reg;

    logic                      q_push_valid;
    logic                      q_push_ready;
    logic [PAYLOAD_W-1:0]      q_push_data;
    logic                      q_pop_valid;
    logic                      q_pop_ready;
    logic [PAYLOAD_W-1:0]      q_pop_data;

    // Writes to an index outside the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= met_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= met_pkg::IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                met_pkg::REG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg_data;
                end
                met_pkg::REG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The mapper accepts a pixel only when idle and turns it into the point c.
    met_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .push_valid   (q_push_valid),
        .push_ready   (q_push_ready),
        .push_data    (q_push_data)
    );

    // Points wait here so the mapper can prepare the next one during a long iteration run.
    met_queue #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (met_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // The core iterates one point at a time and drives the result channel.
    met_core #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_ITER  (MAX_ITER)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .result    (result)
    );

endmodule

// ===== sv/met_checker.sv =====
// Port-level checker of the Mandelbrot escape-time block and its bind to the top level.
// Depends on met_pkg and the assertion macro header.
`include "mandelbrot_escape_time_pixel_macros.svh"

module met_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pix_valid,
    input logic                          pix_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [met_pkg::SHADE_W-1:0]   shade
);

    // Items the block can hold: mapper, queue, core and output register.
    localparam int CAP   = met_pkg::QUEUE_DEPTH + 3;
    localparam int CNT_W = $clog2(CAP + 2);

    logic [CNT_W-1:0] outstanding_reg;
    logic             in_take;
    logic             out_take;

    assign in_take  = pix_valid && pix_ready;
    assign out_take = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else if (in_take && !out_take)
        begin
            outstanding_reg <= outstanding_reg + CNT_W'(1);
        end
        else if (out_take && !in_take)
        begin
            outstanding_reg <= outstanding_reg - CNT_W'(1);
        end
    end

    `MET_ASSERT_NEXT(a_res_valid_holds, clk, rst_n, res_valid && !res_ready, res_valid)
    `MET_ASSERT_NEXT(a_shade_holds, clk, rst_n, res_valid && !res_ready, $stable(shade))
    `MET_ASSERT_IMPL(a_no_extra_item, clk, rst_n, res_valid, outstanding_reg != '0)
    `MET_ASSERT_IMPL(a_within_capacity, clk, rst_n, in_take, outstanding_reg < CNT_W'(CAP))

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pixel.valid),
    .pix_ready (pixel.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .shade     (result.shade)
);
